// ----- rtl/core/cfbs_pkg.sv -----
// Package for the CAN frame bit serializer: shared constants, command and status types.
// Used by cfbs_ctrl, cfbs_dpath and the top level can_frame_bit_serializer.
`default_nettype none
package cfbs_pkg;

	localparam logic [14:0] CRC_POLY  = 15'h4599;
	localparam int          HDR_BITS  = 18;        // id(11) + rtr/ide/r0(3) + dlc(4)
	localparam int          BYTE_BITS = 8;
	localparam int          CRC_BITS  = 15;
	localparam int          SHIFT_W   = HDR_BITS;
	localparam int          CNT_W     = $clog2(HDR_BITS + 1);
	localparam logic [3:0]  MAX_DLC   = 4'd8;
	localparam logic        MODE_HDR  = 1'b0;
	localparam logic        MODE_DATA = 1'b1;
	localparam logic [2:0]  RUN_LIMIT = 3'd5;

	typedef enum logic [1:0] {
		LD_NONE,
		LD_HDR,
		LD_BYTE,
		LD_CRC
	} load_t;

	typedef enum logic [2:0] {
		EM_NONE,
		EM_SOF,
		EM_SHIFT,
		EM_FIXED,
		EM_ERR
	} emit_t;

	typedef struct packed {
		load_t load;
		emit_t emit;
		logic  crc_en;     // feed shifted bits into the CRC
		logic  fixed_bit;
		logic  fixed_end;
		logic  abandon;    // drop any open frame
		logic  close;      // frame finished, restore idle line state
	} dp_cmd_t;

	typedef struct packed {
		logic slot_free;
		logic cnt_zero;
		logic stuff_pending;
		logic bytes_zero;
		logic in_frame;
	} dp_status_t;

endpackage
`default_nettype wire

// ----- rtl/core/cfbs_dpath.sv -----
// Datapath of the CAN frame bit serializer: field shift register, CRC-15, bit stuffing,
// frame bookkeeping and the output register. Depends on cfbs_pkg.
`default_nettype none
module cfbs_dpath
	import cfbs_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire dp_cmd_t     cmd,
	output dp_status_t       status,
	input  wire logic [10:0] frame_id,
	input  wire logic [3:0]  data_length,
	input  wire logic [7:0]  data_byte,
	output logic             bit_valid,
	input  wire logic        bit_stall,
	output logic             line_bit,
	output logic             is_stuff_bit,
	output logic             frame_end,
	output logic             param_error
);

	logic [SHIFT_W-1:0] shreg_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [14:0]        crc_q;
	logic               prev_q;
	logic [2:0]         run_q;
	logic               pend_q;
	logic [3:0]         bytes_q;
	logic               in_frame_q;
	logic               valid_q;
	logic               line_q, stuff_q, end_q, err_q;

	logic               nb;
	logic [2:0]         new_run;
	logic [14:0]        crc_next;

	assign nb       = shreg_q[SHIFT_W-1];
	assign new_run  = (nb == prev_q) ? run_q + 3'd1 : 3'd1;
	assign crc_next = {crc_q[13:0], 1'b0} ^ ((nb ^ crc_q[14]) ? CRC_POLY : 15'd0);

	assign status.slot_free     = !valid_q || !bit_stall;
	assign status.cnt_zero      = (cnt_q == '0);
	assign status.stuff_pending = pend_q;
	assign status.bytes_zero    = (bytes_q == 4'd0);
	assign status.in_frame      = in_frame_q;

	assign bit_valid    = valid_q;
	assign line_bit     = line_q;
	assign is_stuff_bit = stuff_q;
	assign frame_end    = end_q;
	assign param_error  = err_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q      <= '0;
			crc_q      <= '0;
			prev_q     <= 1'b1;
			run_q      <= 3'd0;
			pend_q     <= 1'b0;
			bytes_q    <= 4'd0;
			in_frame_q <= 1'b0;
			valid_q    <= 1'b0;
		end else begin
			if (cmd.emit != EM_NONE)
				valid_q <= 1'b1;
			else if (valid_q && !bit_stall)
				valid_q <= 1'b0;

			unique case (cmd.load)
				LD_HDR: begin
					cnt_q      <= CNT_W'(HDR_BITS);
					crc_q      <= '0;
					bytes_q    <= data_length;
					in_frame_q <= 1'b1;
					pend_q     <= 1'b0;
				end
				LD_BYTE: begin
					cnt_q   <= CNT_W'(BYTE_BITS);
					bytes_q <= bytes_q - 4'd1;
				end
				LD_CRC: cnt_q <= CNT_W'(CRC_BITS);
				default: ;
			endcase

			if (cmd.abandon) begin
				in_frame_q <= 1'b0;
				bytes_q    <= 4'd0;
			end
			if (cmd.close) begin
				prev_q     <= 1'b1;
				run_q      <= 3'd0;
				in_frame_q <= 1'b0;
				bytes_q    <= 4'd0;
			end

			unique case (cmd.emit)
				EM_SOF: begin
					prev_q  <= 1'b0;
					run_q   <= 3'd1;
				end
				EM_SHIFT: begin
					if (pend_q) begin
						// complementary stuff bit opens the next run
						pend_q <= 1'b0;
						prev_q <= !prev_q;
						run_q  <= 3'd1;
					end else begin
						cnt_q  <= cnt_q - CNT_W'(1);
						prev_q <= nb;
						run_q  <= new_run;
						pend_q <= (new_run >= RUN_LIMIT);
						if (cmd.crc_en)
							crc_q <= crc_next;
					end
				end
				default: ;
			endcase
		end
	end

	// payload registers: no reset
	always_ff @(posedge clk) begin
		unique case (cmd.load)
			LD_HDR:  shreg_q <= {frame_id, 3'b000, data_length};
			LD_BYTE: shreg_q <= {data_byte, (SHIFT_W - 8)'(0)};
			LD_CRC:  shreg_q <= {crc_q, (SHIFT_W - 15)'(0)};
			default: ;
		endcase

		unique case (cmd.emit)
			EM_SOF: begin
				line_q  <= 1'b0;
				stuff_q <= 1'b0;
				end_q   <= 1'b0;
				err_q   <= 1'b0;
			end
			EM_SHIFT: begin
				stuff_q <= pend_q;
				end_q   <= 1'b0;
				err_q   <= 1'b0;
				if (pend_q) begin
					line_q <= !prev_q;
				end else begin
					line_q  <= nb;
					shreg_q <= {shreg_q[SHIFT_W-2:0], 1'b0};
				end
			end
			EM_FIXED: begin
				line_q  <= cmd.fixed_bit;
				stuff_q <= 1'b0;
				end_q   <= cmd.fixed_end;
				err_q   <= 1'b0;
			end
			EM_ERR: begin
				line_q  <= 1'b1;
				stuff_q <= 1'b0;
				end_q   <= 1'b1;
				err_q   <= 1'b1;
			end
			default: ;
		endcase
	end

endmodule
`default_nettype wire

// ----- rtl/core/cfbs_ctrl.sv -----
// Controller of the CAN frame bit serializer: item decode and frame sequencing FSM,
// plus the ACK configuration register. Depends on cfbs_pkg.
`default_nettype none
module cfbs_ctrl
	import cfbs_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       item_valid,
	output logic            item_stall,
	input  wire logic       mode,
	input  wire logic [3:0] data_length,
	input  wire logic       cfg_valid,
	output logic            cfg_ready,
	input  wire logic       emit_ack_bits,
	input  wire dp_status_t status,
	output dp_cmd_t         cmd
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ERR,
		ST_SOF,
		ST_FIELD,
		ST_CRC,
		ST_DELIM,
		ST_ACK_SLOT,
		ST_ACK_DELIM
	} state_t;

	state_t state_q, state_d;
	logic   ack_en_q;
	logic   field_done;

	assign item_stall = (state_q != ST_IDLE);
	assign cfg_ready  = (state_q == ST_IDLE);
	assign field_done = status.cnt_zero && !status.stuff_pending;

	always_comb begin
		state_d       = state_q;
		cmd.load      = LD_NONE;
		cmd.emit      = EM_NONE;
		cmd.crc_en    = 1'b0;
		cmd.fixed_bit = 1'b0;
		cmd.fixed_end = 1'b0;
		cmd.abandon   = 1'b0;
		cmd.close     = 1'b0;

		unique case (state_q)
			ST_IDLE: begin
				if (item_valid) begin
					if (mode == MODE_HDR) begin
						if (data_length > MAX_DLC) begin
							cmd.abandon = 1'b1;
							state_d     = ST_ERR;
						end else begin
							cmd.load = LD_HDR;
							state_d  = ST_SOF;
						end
					end else if (status.in_frame && !status.bytes_zero) begin
						cmd.load = LD_BYTE;
						state_d  = ST_FIELD;
					end else begin
						state_d = ST_ERR;
					end
				end
			end
			ST_ERR: begin
				if (status.slot_free) begin
					cmd.emit = EM_ERR;
					state_d  = ST_IDLE;
				end
			end
			ST_SOF: begin
				if (status.slot_free) begin
					cmd.emit = EM_SOF;
					state_d  = ST_FIELD;
				end
			end
			ST_FIELD: begin
				if (field_done) begin
					// last payload byte (or empty frame) goes straight on to the CRC
					if (status.bytes_zero) begin
						cmd.load = LD_CRC;
						state_d  = ST_CRC;
					end else begin
						state_d = ST_IDLE;
					end
				end else if (status.slot_free) begin
					cmd.emit   = EM_SHIFT;
					cmd.crc_en = 1'b1;
				end
			end
			ST_CRC: begin
				if (field_done) begin
					state_d = ST_DELIM;
				end else if (status.slot_free) begin
					cmd.emit = EM_SHIFT;
				end
			end
			ST_DELIM: begin
				if (status.slot_free) begin
					cmd.emit      = EM_FIXED;
					cmd.fixed_bit = 1'b1;
					cmd.fixed_end = !ack_en_q;
					cmd.close     = 1'b1;
					state_d       = ack_en_q ? ST_ACK_SLOT : ST_IDLE;
				end
			end
			ST_ACK_SLOT: begin
				if (status.slot_free) begin
					cmd.emit = EM_FIXED;
					state_d  = ST_ACK_DELIM;
				end
			end
			ST_ACK_DELIM: begin
				if (status.slot_free) begin
					cmd.emit      = EM_FIXED;
					cmd.fixed_bit = 1'b1;
					cmd.fixed_end = 1'b1;
					state_d       = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			ack_en_q <= 1'b1;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready)
				ack_en_q <= emit_ack_bits;
		end
	end

endmodule
`default_nettype wire

// ----- rtl/core/can_frame_bit_serializer.sv -----
// Top level of the CAN 2.0A frame bit serializer.
// Instantiates cfbs_ctrl and cfbs_dpath; depends on cfbs_pkg.

// Turns header and payload byte items into CAN 2.0A data frame line bits (SOF, identifier,
// RTR/IDE/r0, DLC, data, CRC-15, with stuff bits), then the CRC delimiter and optionally
// the ACK slot and ACK delimiter. Within a field, line bits leave one per cycle from an
// output register while the consumer does not stall. One item is handled at a time: a data
// byte is accepted, its bits go out with any stuff bits, and the block returns to idle; a
// header also sends SOF first. The item ending the frame adds the stuffed CRC bits and then
// the CRC delimiter, or with ACK enabled the delimiter, ACK slot and ACK delimiter. An
// error result is a single line bit with frame_end and param_error set.
// emit_ack_bits is written through the cfg handshake while the block is idle.
`default_nettype none
module can_frame_bit_serializer
	import cfbs_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic        emit_ack_bits,
	input  wire logic        item_valid,
	output logic             item_stall,
	input  wire logic        mode,
	input  wire logic [10:0] frame_id,
	input  wire logic [3:0]  data_length,
	input  wire logic [7:0]  data_byte,
	output logic             bit_valid,
	input  wire logic        bit_stall,
	output logic             line_bit,
	output logic             is_stuff_bit,
	output logic             frame_end,
	output logic             param_error
);

	dp_cmd_t    cmd;
	dp_status_t status;

	cfbs_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.mode         (mode),
		.data_length  (data_length),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.emit_ack_bits(emit_ack_bits),
		.status       (status),
		.cmd          (cmd)
	);

	cfbs_dpath u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.status      (status),
		.frame_id    (frame_id),
		.data_length (data_length),
		.data_byte   (data_byte),
		.bit_valid   (bit_valid),
		.bit_stall   (bit_stall),
		.line_bit    (line_bit),
		.is_stuff_bit(is_stuff_bit),
		.frame_end   (frame_end),
		.param_error (param_error)
	);

endmodule
`default_nettype wire

// ----- tb/can_frame_bit_serializer_tb.sv -----
// Self-checking testbench for can_frame_bit_serializer: drives header and payload transfers,
// predicts the stuffed CAN 2.0A line bits with CRC-15 and checks every output transfer.
// Depends on cfbs_pkg and the RTL of can_frame_bit_serializer.
module can_frame_bit_serializer_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import cfbs_pkg::*;

	typedef struct packed {
		logic       mode;
		logic [10:0] id;
		logic [3:0]  dlc;
		logic [7:0]  data;
	} can_item_t;

	typedef struct packed {
		logic line_bit;
		logic is_stuff_bit;
		logic frame_end;
		logic param_error;
	} bus_bit_t;

	class frame_bit_scoreboard;
		logic        ack_en;
		logic [14:0] crc;
		logic [2:0]  run_len;
		logic        prev_bit;
		logic [3:0]  bytes_left;
		logic        frame_open;
		bus_bit_t    expected_bits[$];
		int          mismatches;

		function new();
			ack_en     = 1'b1;
			crc        = '0;
			run_len    = '0;
			prev_bit   = 1'b1;
			bytes_left = '0;
			frame_open = 1'b0;
			mismatches = 0;
		endfunction

		function void push_bit(logic b, logic s, logic e, logic er);
			expected_bits.push_back(bus_bit_t'{b, s, e, er});
		endfunction

		// a stuff bit starts the next run
		function void send_stuffed(logic b);
			push_bit(b, 1'b0, 1'b0, 1'b0);
			if (b == prev_bit) begin
				run_len++;
			end else begin
				run_len  = 3'd1;
				prev_bit = b;
			end
			if (run_len >= RUN_LIMIT) begin
				push_bit(~b, 1'b1, 1'b0, 1'b0);
				prev_bit = ~b;
				run_len  = 3'd1;
			end
		endfunction

		function void send_field(logic [10:0] value, int width);
			logic b;
			logic top;
			for (int i = width - 1; i >= 0; i--) begin
				b   = value[i];
				top = crc[14];
				crc = {crc[13:0], 1'b0};
				if (b ^ top)
					crc ^= CRC_POLY;
				send_stuffed(b);
			end
		endfunction

		// CRC bits are stuffed, delimiters and ACK are not
		function void close_frame();
			logic [14:0] crc_out;
			crc_out = crc;
			for (int i = 14; i >= 0; i--)
				send_stuffed(crc_out[i]);
			push_bit(1'b1, 1'b0, ~ack_en, 1'b0);
			if (ack_en) begin
				push_bit(1'b0, 1'b0, 1'b0, 1'b0);
				push_bit(1'b1, 1'b0, 1'b1, 1'b0);
			end
			prev_bit   = 1'b1;
			run_len    = '0;
			frame_open = 1'b0;
			bytes_left = '0;
		endfunction

		function void note_item(can_item_t it);
			if (it.mode == MODE_HDR) begin
				if (it.dlc > MAX_DLC) begin
					frame_open = 1'b0;
					bytes_left = '0;
					push_bit(1'b1, 1'b0, 1'b1, 1'b1);
					return;
				end
				crc = '0;
				// SOF leaves a zero CRC unchanged
				push_bit(1'b0, 1'b0, 1'b0, 1'b0);
				prev_bit = 1'b0;
				run_len  = 3'd1;
				send_field(it.id, 11);
				send_field(11'd0, 3);
				send_field(11'(it.dlc), 4);
				frame_open = 1'b1;
				bytes_left = it.dlc;
				if (it.dlc == 4'd0)
					close_frame();
				return;
			end
			if (!frame_open || bytes_left == 4'd0) begin
				push_bit(1'b1, 1'b0, 1'b1, 1'b1);
				return;
			end
			send_field(11'(it.data), BYTE_BITS);
			bytes_left--;
			if (bytes_left == 4'd0)
				close_frame();
		endfunction

		function void check_bit(bus_bit_t got);
			bus_bit_t want;
			if (expected_bits.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: unexpected bit line=%b stuff=%b end=%b err=%b", $time,
						got.line_bit, got.is_stuff_bit, got.frame_end, got.param_error);
				return;
			end
			want = expected_bits.pop_front();
			if (want !== got) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: mismatch line/stuff/end/err expected %b%b%b%b got %b%b%b%b",
						$time, want.line_bit, want.is_stuff_bit, want.frame_end,
						want.param_error, got.line_bit, got.is_stuff_bit, got.frame_end,
						got.param_error);
			end
		endfunction

		function int pending();
			return expected_bits.size();
		endfunction
	endclass

	localparam logic [63:0] EDGE_BYTES = 64'h00FF_00FF_AA55_0FF0;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic        emit_ack_bits = 1'b1;
	logic        item_valid = 1'b0;
	logic        item_stall;
	logic        mode = MODE_HDR;
	logic [10:0] frame_id = '0;
	logic [3:0]  data_length = '0;
	logic [7:0]  data_byte = '0;
	logic        bit_valid;
	logic        bit_stall = 1'b0;
	logic        line_bit;
	logic        is_stuff_bit;
	logic        frame_end;
	logic        param_error;

	frame_bit_scoreboard sb;
	int src_idle = 0;
	int snk_idle = 0;
	int items_sent = 0;

	can_frame_bit_serializer dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.emit_ack_bits(emit_ack_bits),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.mode         (mode),
		.frame_id     (frame_id),
		.data_length  (data_length),
		.data_byte    (data_byte),
		.bit_valid    (bit_valid),
		.bit_stall    (bit_stall),
		.line_bit     (line_bit),
		.is_stuff_bit (is_stuff_bit),
		.frame_end    (frame_end),
		.param_error  (param_error)
	);

	always #5 clk = ~clk;

	always @(negedge clk) begin
		bit_stall <= ($urandom_range(0, 99) < snk_idle);
	end

	always @(posedge clk) begin
		if (arst_n && bit_valid && !bit_stall)
			sb.check_bit(bus_bit_t'{line_bit, is_stuff_bit, frame_end, param_error});
	end

	function automatic can_item_t make_item(logic m, logic [10:0] id, logic [3:0] dlc,
			logic [7:0] data);
		return can_item_t'{m, id, dlc, data};
	endfunction

	// bias toward all-zero and all-one values so long runs get stuffed
	function automatic logic [10:0] pick_id();
		case ($urandom_range(0, 3))
			0: return '0;
			1: return '1;
			default: return 11'($urandom);
		endcase
	endfunction

	function automatic logic [7:0] pick_byte();
		case ($urandom_range(0, 3))
			0: return '0;
			1: return '1;
			default: return 8'($urandom);
		endcase
	endfunction

	task automatic send_item(input can_item_t it);
		@(negedge clk);
		while ($urandom_range(0, 99) < src_idle) begin
			item_valid <= 1'b0;
			@(negedge clk);
		end
		item_valid  <= 1'b1;
		mode        <= it.mode;
		frame_id    <= it.id;
		data_length <= it.dlc;
		data_byte   <= it.data;
		@(posedge clk);
		while (item_stall)
			@(posedge clk);
		sb.note_item(it);
		items_sent++;
	endtask

	task automatic send_random_frame();
		can_item_t it;
		int n_bytes;
		it = make_item(MODE_HDR, pick_id(), 4'($urandom_range(0, 8)), 8'($urandom));
		send_item(it);
		n_bytes = it.dlc;
		// now and then cut the frame short so a later header abandons it
		if (n_bytes != 0 && $urandom_range(0, 7) == 0)
			n_bytes = $urandom_range(0, n_bytes - 1);
		repeat (n_bytes)
			send_item(make_item(MODE_DATA, 11'($urandom), 4'($urandom), pick_byte()));
	endtask

	task automatic random_step();
		if ($urandom_range(0, 9) == 0)
			send_item(make_item(1'($urandom), 11'($urandom), 4'($urandom), 8'($urandom)));
		else
			send_random_frame();
	endtask

	task automatic wait_drained();
		@(negedge clk);
		item_valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_ack_cfg(input logic v);
		@(negedge clk);
		cfg_valid     <= 1'b1;
		emit_ack_bits <= v;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		sb.ack_en = v;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	initial begin
		sb = new();
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		src_idle = 37;
		snk_idle = 53;
		write_ack_cfg(1'b1);

		send_item(make_item(MODE_HDR, 11'h000, 4'd0, 8'h00));
		send_item(make_item(MODE_HDR, 11'h7FF, MAX_DLC, 8'hFF));
		for (int i = 0; i < 8; i++)
			send_item(make_item(MODE_DATA, 11'h000, 4'h0, EDGE_BYTES[63 - 8 * i -: 8]));
		// byte outside any frame
		send_item(make_item(MODE_DATA, 11'h7FF, 4'hF, 8'hA5));
		send_item(make_item(MODE_HDR, 11'h2AA, 4'd9, 8'h00));
		send_item(make_item(MODE_HDR, 11'h555, 4'd15, 8'hFF));
		// new frame after two bad lengths, left open so the next header abandons it
		send_item(make_item(MODE_HDR, 11'h555, 4'd3, 8'h00));
		send_item(make_item(MODE_DATA, 11'h000, 4'd0, 8'h00));
		send_item(make_item(MODE_HDR, 11'h123, 4'd1, 8'h00));
		send_item(make_item(MODE_DATA, 11'h000, 4'd0, 8'h81));
		// frame left open, then a bad length drops it and the next byte has no frame
		send_item(make_item(MODE_HDR, 11'h000, 4'd2, 8'h00));
		send_item(make_item(MODE_DATA, 11'h000, 4'd0, 8'hFF));
		send_item(make_item(MODE_HDR, 11'h3C3, 4'd12, 8'h00));
		send_item(make_item(MODE_DATA, 11'h000, 4'd0, 8'h3C));

		while (items_sent < 70)
			random_step();
		wait_drained();

		write_ack_cfg(1'b0);
		src_idle = 53;
		snk_idle = 37;
		while (items_sent < 105)
			random_step();
		wait_drained();
		while (items_sent < 140)
			random_step();
		wait_drained();

		write_ack_cfg(1'b1);
		src_idle = 0;
		snk_idle = 0;
		while (items_sent < 210)
			random_step();
		wait_drained();

		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("can_frame_bit_serializer_tb OK");
		else
			$display("can_frame_bit_serializer_tb NOT OK");
		$finish;
	end

	initial begin
		#3_000_000;
		$display("can_frame_bit_serializer_tb NOT OK");
		$finish;
	end

endmodule
